// ===== hw/rtl/hpp_pkg.sv =====
// Shared types and constants for the heightmap perspective projection block.
// Holds the configuration register map, reset values and the config bundle.
// No dependencies.
`timescale 1ns / 1ps

package hpp_pkg;

  localparam int unsigned COEFF_FRAC_BITS = 14;
  localparam int unsigned GRID_MAX        = 4096;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned COORD_W    = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_DEPTH  = 3'd2,
    REG_GRID_W = 3'd3,
    REG_GRID_H = 3'd4,
    REG_SCREEN = 3'd5
  } cfg_reg_e;

  localparam logic signed [15:0] COS_RESET    = 16'sd16384;
  localparam logic signed [15:0] SIN_RESET    = 16'sd0;
  localparam logic [15:0]        DEPTH_RESET  = 16'd1000;
  localparam logic [12:0]        GRID_RESET   = 13'd16;
  localparam logic [12:0]        SCREEN_RESET = 13'd1000;

  localparam logic [COORD_W-1:0] BEHIND_COORD = 16'hFFFF;
  localparam logic [COORD_W-1:0] SAT_POS      = 16'h7FFF;
  localparam logic [COORD_W-1:0] SAT_NEG      = 16'h8000;

  typedef struct packed {
    logic signed [15:0] cos_coeff;
    logic signed [15:0] sin_coeff;
    logic [15:0]        depth_offset;
    logic [11:0]        half_w;
    logic [11:0]        half_h;
    logic [12:0]        screen_size;
  } cfg_t;

endpackage

// ===== hw/rtl/heightmap_perspective_project.sv =====
// Heightmap perspective projection, top level: config registers, front, queue, back.
// Throughput one item per cycle while out_ready_i does not hold the back end.
// Every stage, the 15 restoring divider steps included, takes a new item each cycle unless the output stalls.
// Reset: config registers take their defaults, pipeline and queue come up empty.
// Uses hpp_pkg, hpp_front, hpp_queue, hpp_back.
`timescale 1ns / 1ps

module heightmap_perspective_project #(
  parameter int unsigned CoeffFracBits = hpp_pkg::COEFF_FRAC_BITS,
  parameter int unsigned GridMax       = hpp_pkg::GRID_MAX,
  parameter int unsigned QueueDepth    = hpp_pkg::QUEUE_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hpp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [hpp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [11:0]                      column_i,
  input  logic [11:0]                      row_i,
  input  logic signed [15:0]               height_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [15:0]               screen_x_o,
  output logic signed [15:0]               screen_y_o,
  output logic                             in_front_o
);
  import hpp_pkg::*;

  localparam int unsigned ValW = (CoeffFracBits + 18 > 34) ? CoeffFracBits + 18 : 34;
  localparam int unsigned EntW = 3 * ValW + 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic signed [15:0] cos_q, sin_q;
  logic [15:0]        depth_q;
  logic [12:0]        grid_w_q, grid_h_q, screen_q;
  logic [31:0]        gw_clamp, gh_clamp;
  cfg_t               cfg;

  logic                   accept;
  logic [1:0]             inflight;
  logic                   q_push, q_pop, q_valid;
  logic [CntW-1:0]        q_count;
  logic [CntW:0]          credit;
  logic signed [ValW-1:0] f_x, f_y;
  logic [ValW-1:0]        f_dist;
  logic                   f_front;
  logic [EntW-1:0]        q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q    <= COS_RESET;
      sin_q    <= SIN_RESET;
      depth_q  <= DEPTH_RESET;
      grid_w_q <= GRID_RESET;
      grid_h_q <= GRID_RESET;
      screen_q <= SCREEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COS:    cos_q    <= $signed(cfg_data_i);
        REG_SIN:    sin_q    <= $signed(cfg_data_i);
        REG_DEPTH:  depth_q  <= cfg_data_i;
        REG_GRID_W: grid_w_q <= cfg_data_i[12:0];
        REG_GRID_H: grid_h_q <= cfg_data_i[12:0];
        REG_SCREEN: screen_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign gw_clamp = (32'(grid_w_q) > 32'(GridMax)) ? 32'(GridMax) : 32'(grid_w_q);
  assign gh_clamp = (32'(grid_h_q) > 32'(GridMax)) ? 32'(GridMax) : 32'(grid_h_q);

  always_comb begin
    cfg.cos_coeff    = cos_q;
    cfg.sin_coeff    = sin_q;
    cfg.depth_offset = depth_q;
    cfg.half_w       = 12'(gw_clamp >> 1);
    cfg.half_h       = 12'(gh_clamp >> 1);
    cfg.screen_size  = screen_q;
  end

  assign credit     = (CntW+1)'(q_count) + (CntW+1)'(inflight);
  assign in_ready_o = credit < (CntW+1)'(QueueDepth);
  assign accept     = in_valid_i && in_ready_o;

  hpp_front #(
    .CoeffFracBits(CoeffFracBits)
  ) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i          (cfg),
    .accept_i       (accept),
    .column_i,
    .row_i,
    .height_sample_i,
    .inflight_o     (inflight),
    .push_o         (q_push),
    .x_o            (f_x),
    .y_o            (f_y),
    .dist_o         (f_dist),
    .in_front_o     (f_front)
  );

  assign q_wdata = {f_x, f_y, f_dist, f_front};

  hpp_queue #(
    .Width(EntW),
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata),
    .count_o (q_count)
  );

  hpp_back #(
    .CoeffFracBits(CoeffFracBits)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg),
    .q_valid_i   (q_valid),
    .q_x_i       ($signed(q_rdata[EntW-1 -: ValW])),
    .q_y_i       ($signed(q_rdata[2*ValW -: ValW])),
    .q_dist_i    (q_rdata[ValW:1]),
    .q_front_i   (q_rdata[0]),
    .q_pop_o     (q_pop),
    .out_valid_o,
    .out_ready_i,
    .screen_x_o,
    .screen_y_o,
    .in_front_o
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_count != CntW'(QueueDepth)))
    else $error("item pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> (q_count != '0))
    else $error("item popped from empty queue");

  a_credit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (credit <= (CntW+1)'(QueueDepth)))
    else $error("queue credit exceeded after accept");

endmodule

// ===== hw/rtl/hpp_front.sv =====
// Front end: centers the grid point, rotates it about the x axis and classifies it.
// Two stages: products, then sums and the in-front check. Uses hpp_pkg.
`timescale 1ns / 1ps

module hpp_front #(
  parameter int unsigned CoeffFracBits = hpp_pkg::COEFF_FRAC_BITS,
  localparam int unsigned ValW = (CoeffFracBits + 18 > 34) ? CoeffFracBits + 18 : 34
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hpp_pkg::cfg_t          cfg_i,
  input  logic                   accept_i,
  input  logic [11:0]            column_i,
  input  logic [11:0]            row_i,
  input  logic signed [15:0]     height_sample_i,
  output logic [1:0]             inflight_o,
  output logic                   push_o,
  output logic signed [ValW-1:0] x_o,
  output logic signed [ValW-1:0] y_o,
  output logic [ValW-1:0]        dist_o,
  output logic                   in_front_o
);
  import hpp_pkg::*;

  localparam int unsigned F = CoeffFracBits;

  logic                   v1_q, v2_q;
  logic signed [12:0]     row_s;
  logic signed [12:0]     xc_d, xc_q;
  logic signed [28:0]     cr_d, cr_q, sr_d, sr_q;
  logic signed [31:0]     sh_d, sh_q, ch_d, ch_q;
  logic signed [ValW-1:0] hh_s, dep_s, x_d, y_d, dist_d;
  logic signed [ValW-1:0] x_q, y_q, dist_q;
  logic                   front_d, front_q;

  assign row_s = $signed({1'b0, row_i});
  assign xc_d  = $signed({1'b0, column_i}) - $signed({1'b0, cfg_i.half_w});
  assign cr_d  = 29'(cfg_i.cos_coeff) * 29'(row_s);
  assign sr_d  = 29'(cfg_i.sin_coeff) * 29'(row_s);
  assign sh_d  = 32'(cfg_i.sin_coeff) * 32'(height_sample_i);
  assign ch_d  = 32'(cfg_i.cos_coeff) * 32'(height_sample_i);

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      xc_q <= xc_d;
      cr_q <= cr_d;
      sr_q <= sr_d;
      sh_q <= sh_d;
      ch_q <= ch_d;
    end
  end

  assign hh_s   = $signed({{(ValW-12-F){1'b0}}, cfg_i.half_h, {F{1'b0}}});
  assign dep_s  = $signed({{(ValW-16-F){1'b0}}, cfg_i.depth_offset, {F{1'b0}}});
  assign x_d    = $signed({{(ValW-13-F){xc_q[12]}}, xc_q, {F{1'b0}}});
  assign y_d    = ValW'(cr_q) + ValW'(sh_q) - hh_s;
  assign dist_d = ValW'(sr_q) + dep_s - ValW'(ch_q);
  assign front_d = !dist_d[ValW-1] && (dist_d != '0);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      x_q     <= x_d;
      y_q     <= y_d;
      dist_q  <= dist_d;
      front_q <= front_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept_i;
      v2_q <= v1_q;
    end
  end

  assign inflight_o = {1'b0, v1_q} + {1'b0, v2_q};
  assign push_o     = v2_q;
  assign x_o        = x_q;
  assign y_o        = y_q;
  assign dist_o     = dist_q;
  assign in_front_o = front_q;

endmodule

// ===== hw/rtl/hpp_queue.sv =====
// Short register queue between the front end and the projection back end.
// Written at the tail, read at the head. No dependencies.
`timescale 1ns / 1ps

module hpp_queue #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = hpp_pkg::QUEUE_DEPTH,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  output logic [CntW-1:0]  count_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

// ===== hw/rtl/hpp_back.sv =====
// Back end: perspective scale, rounded division pipeline and saturation per axis.
// One restoring step per stage, output register at the end. Uses hpp_pkg.
`timescale 1ns / 1ps

module hpp_back #(
  parameter int unsigned CoeffFracBits = hpp_pkg::COEFF_FRAC_BITS,
  localparam int unsigned ValW = (CoeffFracBits + 18 > 34) ? CoeffFracBits + 18 : 34
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hpp_pkg::cfg_t          cfg_i,
  input  logic                   q_valid_i,
  input  logic signed [ValW-1:0] q_x_i,
  input  logic signed [ValW-1:0] q_y_i,
  input  logic [ValW-1:0]        q_dist_i,
  input  logic                   q_front_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [15:0]     screen_x_o,
  output logic signed [15:0]     screen_y_o,
  output logic                   in_front_o
);
  import hpp_pkg::*;

  localparam int unsigned NW    = ValW + 15;
  localparam int unsigned RW    = ValW + 16;
  localparam int unsigned QUO_W = COORD_W - 1;

  logic adv;

  // stage 0: offset by distance
  logic                 v0_q, f0_q;
  logic signed [ValW:0] dv0_q [2];
  logic [ValW-1:0]      d0_q;

  // stage 1: scale by screen size
  logic                 v1_q, f1_q;
  logic signed [NW-1:0] n1_q [2];
  logic [ValW-1:0]      d1_q;

  // stage 2: magnitude plus rounding term
  logic                 v2_q, f2_q;
  logic [RW-1:0]        num2_q [2];
  logic                 neg2_q [2];
  logic [RW-1:0]        den2_q;
  logic signed [NW-1:0] sel2 [2];
  logic [RW-1:0]        num2_d [2];

  // divider stages
  logic             vd_q  [QUO_W+1];
  logic             fd_q  [QUO_W+1];
  logic             neg_q [QUO_W+1][2];
  logic             ovf_q [QUO_W+1][2];
  logic [QUO_W-1:0] quo_q [QUO_W+1][2];
  logic [RW-1:0]    rem_q [QUO_W][2];
  logic [RW-1:0]    den_q [QUO_W];
  logic             ovf_d [2];
  logic [RW-1:0]    rem_d [1:QUO_W-1][2];
  logic [QUO_W-1:0] quo_d [1:QUO_W][2];

  // output register
  logic                 out_valid_q, front_q;
  logic [COORD_W-1:0]   res_d [2];
  logic [COORD_W-1:0]   res_q [2];
  logic [COORD_W-1:0]   mag [2];

  assign adv     = !out_valid_q || out_ready_i;
  assign q_pop_o = q_valid_i && adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d0_q     <= q_dist_i;
      f0_q     <= q_front_i;
      dv0_q[0] <= $signed({1'b0, q_dist_i}) + $signed({q_x_i[ValW-1], q_x_i});
      dv0_q[1] <= $signed({1'b0, q_dist_i}) + $signed({q_y_i[ValW-1], q_y_i});
      d1_q     <= d0_q;
      f1_q     <= f0_q;
      f2_q     <= f1_q;
      den2_q   <= {{(RW-ValW-1){1'b0}}, d1_q, 1'b0};
      for (int a = 0; a < 2; a++) begin
        n1_q[a]   <= NW'($signed({1'b0, cfg_i.screen_size})) * NW'(dv0_q[a]);
        num2_q[a] <= num2_d[a];
        neg2_q[a] <= n1_q[a][NW-1];
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sel2[a]   = n1_q[a][NW-1] ? ~n1_q[a] : n1_q[a];
      num2_d[a] = {{(RW-ValW){1'b0}}, d1_q}
                + {{(RW-NW+1){1'b0}}, sel2[a][NW-2:0]}
                + {{(RW-1){1'b0}}, n1_q[a][NW-1]};
      ovf_d[a]  = num2_q[a] >= (den2_q << QUO_W);
    end
    for (int s = 1; s <= QUO_W; s++) begin
      for (int a = 0; a < 2; a++) begin
        if (rem_q[s-1][a] >= (den_q[s-1] << (QUO_W - s))) begin
          quo_d[s][a] = quo_q[s-1][a] | (QUO_W'(1) << (QUO_W - s));
        end else begin
          quo_d[s][a] = quo_q[s-1][a];
        end
      end
    end
    for (int s = 1; s < QUO_W; s++) begin
      for (int a = 0; a < 2; a++) begin
        if (rem_q[s-1][a] >= (den_q[s-1] << (QUO_W - s))) begin
          rem_d[s][a] = rem_q[s-1][a] - (den_q[s-1] << (QUO_W - s));
        end else begin
          rem_d[s][a] = rem_q[s-1][a];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fd_q[0]  <= f2_q;
      den_q[0] <= den2_q;
      for (int a = 0; a < 2; a++) begin
        neg_q[0][a] <= neg2_q[a];
        ovf_q[0][a] <= ovf_d[a];
        rem_q[0][a] <= num2_q[a];
        quo_q[0][a] <= '0;
      end
      for (int s = 1; s <= QUO_W; s++) begin
        fd_q[s] <= fd_q[s-1];
        for (int a = 0; a < 2; a++) begin
          neg_q[s][a] <= neg_q[s-1][a];
          ovf_q[s][a] <= ovf_q[s-1][a];
          quo_q[s][a] <= quo_d[s][a];
        end
      end
      for (int s = 1; s < QUO_W; s++) begin
        den_q[s] <= den_q[s-1];
        for (int a = 0; a < 2; a++) begin
          rem_q[s][a] <= rem_d[s][a];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mag[a] = {1'b0, quo_q[QUO_W][a]};
      if (!fd_q[QUO_W]) begin
        res_d[a] = BEHIND_COORD;
      end else if (ovf_q[QUO_W][a]) begin
        res_d[a] = neg_q[QUO_W][a] ? SAT_NEG : SAT_POS;
      end else begin
        res_d[a] = neg_q[QUO_W][a] ? -mag[a] : mag[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      front_q  <= fd_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q        <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      for (int s = 0; s <= QUO_W; s++) begin
        vd_q[s] <= 1'b0;
      end
    end else if (adv) begin
      v0_q    <= q_valid_i;
      v1_q    <= v0_q;
      v2_q    <= v1_q;
      vd_q[0] <= v2_q;
      for (int s = 1; s <= QUO_W; s++) begin
        vd_q[s] <= vd_q[s-1];
      end
      out_valid_q <= vd_q[QUO_W];
    end
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = $signed(res_q[0]);
  assign screen_y_o  = $signed(res_q[1]);
  assign in_front_o  = front_q;

endmodule

// ===== test/tb_heightmap_perspective_project.sv =====
// Self-checking testbench for heightmap_perspective_project: grid points in, screen pixels out.
// Predicts every pixel from its own copy of the config registers, under random flow control.
// Depends on hpp_pkg and the heightmap_perspective_project RTL.
`timescale 1ns / 1ps

module tb_heightmap_perspective_project;
  import hpp_pkg::*;

  localparam int ITEMS_PER_PHASE = 76;
  localparam int NUM_PHASES      = 9;
  localparam int LONG_HOLD       = 80;
  localparam int DRAIN_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT  = 2000;

  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_IDX_B = 3'd7;

  typedef struct packed {
    logic [11:0]        column;
    logic [11:0]        row;
    logic signed [15:0] height;
  } grid_point_t;

  typedef struct packed {
    logic [15:0] screen_x;
    logic [15:0] screen_y;
    logic        in_front;
  } pixel_t;

  typedef enum int {
    SINK_OPEN,
    SINK_HALF,
    SINK_MOSTLY,
    SINK_EVERY_FOURTH
  } sink_mode_e;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i       = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  logic [11:0]           column_i        = '0;
  logic [11:0]           row_i           = '0;
  logic signed [15:0]    height_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic signed [15:0]    screen_x_o;
  logic signed [15:0]    screen_y_o;
  logic                  in_front_o;

  // Shadow copy of the config registers
  longint cos_q    = longint'(COS_RESET);
  longint sin_q    = longint'(SIN_RESET);
  longint depth_q  = longint'(DEPTH_RESET);
  longint grid_w_q = longint'(GRID_RESET);
  longint grid_h_q = longint'(GRID_RESET);
  longint screen_q = longint'(SCREEN_RESET);

  grid_point_t point_queue[$];
  pixel_t      expected_pix[$];
  int          mismatches   = 0;
  int          quiet_cycles = 0;
  int          results_seen = 0;
  int          burst_left   = 0;
  int          gap_left     = 0;
  int          hold_left    = 0;
  int          mode_left    = 0;
  sink_mode_e  sink_mode    = SINK_OPEN;

  heightmap_perspective_project u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .column_i       (column_i),
    .row_i          (row_i),
    .height_sample_i(height_sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .screen_x_o     (screen_x_o),
    .screen_y_o     (screen_y_o),
    .in_front_o     (in_front_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // round(s * (d + v) / (2 * d)), ties away from zero, saturated to 16 bits
  function automatic logic [15:0] round_pixel(longint v, longint d, longint s);
    longint n;
    longint q;
    n = s * (d + v);
    if (n >= 0) begin
      q = (n + d) / (2 * d);
    end else begin
      q = -((-n + d) / (2 * d));
    end
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic pixel_t project_point(logic [11:0] col, logic [11:0] row,
                                           logic signed [15:0] hgt);
    longint unit;
    longint half_w;
    longint half_h;
    longint hs;
    longint x;
    longint y;
    longint z;
    pixel_t r;
    unit   = longint'(1) << COEFF_FRAC_BITS;
    half_w = ((grid_w_q > longint'(GRID_MAX)) ? longint'(GRID_MAX) : grid_w_q) / 2;
    half_h = ((grid_h_q > longint'(GRID_MAX)) ? longint'(GRID_MAX) : grid_h_q) / 2;
    hs     = longint'(hgt);
    x = (longint'(col) - half_w) * unit;
    y = cos_q * longint'(row) + sin_q * hs - half_h * unit;
    z = cos_q * hs - sin_q * longint'(row) - depth_q * unit;
    if (z < 0) begin
      r.screen_x = round_pixel(x, -z, screen_q);
      r.screen_y = round_pixel(y, -z, screen_q);
      r.in_front = 1'b1;
    end else begin
      r.screen_x = BEHIND_COORD;
      r.screen_y = BEHIND_COORD;
      r.in_front = 1'b0;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_COS:    cos_q    = longint'($signed(data));
      REG_SIN:    sin_q    = longint'($signed(data));
      REG_DEPTH:  depth_q  = longint'(data);
      REG_GRID_W: grid_w_q = longint'(data[12:0]);
      REG_GRID_H: grid_h_q = longint'(data[12:0]);
      REG_SCREEN: screen_q = longint'(data[12:0]);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_setting(input logic [15:0] c, input logic [15:0] s,
                               input logic [15:0] dep, input logic [15:0] gw,
                               input logic [15:0] gh, input logic [15:0] scr);
    write_reg(REG_COS, c);
    write_reg(REG_SIN, s);
    write_reg(REG_DEPTH, dep);
    write_reg(REG_GRID_W, gw);
    write_reg(REG_GRID_H, gh);
    write_reg(REG_SCREEN, scr);
  endtask

  task automatic wait_drained();
    while (!(point_queue.size() == 0 && !in_valid_i && expected_pix.size() == 0))
      @(posedge clk_i);
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d (0x%h) got %0d (0x%h)",
               $time, field, $signed(want), want, $signed(got), got);
      mismatches++;
    end
  endtask

  // Sender: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin : p_feed
    grid_point_t pt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        expected_pix.push_back(project_point(column_i, row_i, height_sample_i));
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (point_queue.size() > 0) begin
          pt = point_queue.pop_front();
          column_i        <= pt.column;
          row_i           <= pt.row;
          height_sample_i <= pt.height;
          in_valid_i      <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver and result check
  always @(posedge clk_i or negedge rst_ni) begin : p_sink
    pixel_t want;
    logic   rdy;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (results_seen == 120 || results_seen == 430) hold_left = LONG_HOLD;
        if (expected_pix.size() == 0) begin
          $display("%0t ns: unexpected result x=%0d y=%0d in_front=%0b",
                   $time, screen_x_o, screen_y_o, in_front_o);
          mismatches++;
        end else begin
          want = expected_pix.pop_front();
          check_field("screen_x", want.screen_x, screen_x_o);
          check_field("screen_y", want.screen_y, screen_y_o);
          check_field("in_front", {15'd0, want.in_front}, {15'd0, in_front_o});
        end
      end
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN:   rdy = 1'b1;
          SINK_HALF:   rdy = 1'($urandom_range(0, 1));
          SINK_MOSTLY: rdy = ($urandom_range(0, 3) != 0);
          default:     rdy = ((mode_left % 4) != 0);
        endcase
      end
      out_ready_i <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : p_watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t ns: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : p_main
    grid_point_t pt;
    int          span_w;
    int          span_h;
    int          span_z;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed points under the reset config
    point_queue.push_back('{12'd0, 12'd0, -16'sd32768});
    point_queue.push_back('{12'd4095, 12'd4095, 16'sd32767});
    point_queue.push_back('{12'd0, 12'd0, 16'sd0});
    point_queue.push_back('{12'd4095, 12'd0, 16'sd0});
    point_queue.push_back('{12'd0, 12'd4095, 16'sd0});
    point_queue.push_back('{12'd8, 12'd8, 16'sd0});
    point_queue.push_back('{12'd1, 12'd0, 16'sd0});
    point_queue.push_back('{12'd4095, 12'd0, 16'sd999});
    point_queue.push_back('{12'd0, 12'd4095, 16'sd999});
    point_queue.push_back('{12'd7, 12'd9, 16'sd1000});
    point_queue.push_back('{12'd3, 12'd3, 16'sd1001});
    point_queue.push_back('{12'd3, 12'd3, 16'sd998});
    point_queue.push_back('{12'd2048, 12'd2048, -16'sd1});
    point_queue.push_back('{12'hAAA, 12'h555, 16'sh5555});
    point_queue.push_back('{12'h555, 12'hAAA, -16'sd21846});
    point_queue.push_back('{12'd4095, 12'd4095, -16'sd32768});

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      case (p)
        1: apply_setting(16'd11585, 16'd11585, 16'd300, 16'd64, 16'd48, 16'd640);
        2: begin
          apply_setting(16'h8000, 16'h7FFF, 16'd0, 16'd8191, 16'd0, 16'd8191);
          write_reg(UNMAPPED_IDX_A, 16'hFFFF);
          write_reg(UNMAPPED_IDX_B, 16'h0000);
        end
        3: apply_setting(16'h7FFF, 16'h8000, 16'hFFFF, 16'd4096, 16'd4096, 16'd1);
        4: apply_setting(16'd0, 16'd16384, 16'd5, 16'd1, 16'd1, 16'd0);
        5: apply_setting(16'hC000, 16'd0, 16'd2, 16'h2003, 16'hE007, 16'd4095);
        6: apply_setting(16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 16'($urandom), 16'($urandom));
        7: apply_setting(16'($urandom_range(0, 32768) - 16384),
                         16'($urandom_range(0, 32768) - 16384),
                         16'($urandom_range(0, 2000)), 16'($urandom_range(1, 4096)),
                         16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)));
        8: apply_setting(COS_RESET, SIN_RESET, DEPTH_RESET, 16'(GRID_RESET),
                         16'(GRID_RESET), 16'(SCREEN_RESET));
        default: ;
      endcase
      span_w = int'((grid_w_q < 1) ? 1 : ((grid_w_q > 4096) ? 4096 : grid_w_q));
      span_h = int'((grid_h_q < 1) ? 1 : ((grid_h_q > 4096) ? 4096 : grid_h_q));
      span_z = int'((depth_q + 64 > 32767) ? 32767 : depth_q + 64);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 1) == 0) begin
          pt.column = 12'($urandom);
          pt.row    = 12'($urandom);
          pt.height = 16'($urandom);
        end else begin
          pt.column = 12'($urandom_range(0, span_w - 1));
          pt.row    = 12'($urandom_range(0, span_h - 1));
          pt.height = 16'(int'($urandom_range(0, 2 * span_z)) - span_z);
        end
        point_queue.push_back(pt);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_pix.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
